### src/hvt_pkg.sv
// Package for the homogeneous vertex transform unit: widths, codes, payload and state types.
package hvt_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int TERM_W  = PROD_W - FRAC_W;
  // Three floored products of at most 2^46 plus one coefficient stay below 2^48.
  localparam int ACC_W   = 50;
  // Quotient bits kept by the divider before saturation.
  localparam int QUO_W   = COORD_W + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic [COORD_W-1:0] COEF_ONE  = 32'h0001_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                      op;
    logic [3:0]                coef_index;
    logic signed [COORD_W-1:0] coef_value;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } hvt_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      zero_w;
    logic                      overflow;
  } hvt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } hvt_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_ITER,
    DV_DONE
  } hvt_div_state_t;

  // Identity matrix entry for a row*4+column position.
  function automatic logic [COORD_W-1:0] identity_coef(input logic [3:0] idx);
    return (idx[3:2] == idx[1:0]) ? COEF_ONE : '0;
  endfunction

endpackage

### src/hvt_div.sv
// Restoring divider: signed (num * 2^16) / den, truncated toward zero and saturated to 32 bits.
module hvt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [hvt_pkg::ACC_W-1:0]   num,
  input  logic signed [hvt_pkg::ACC_W-1:0]   den,
  output logic                               done,
  output logic signed [hvt_pkg::COORD_W-1:0] quo,
  output logic                               ovf
);

  localparam int MAG_W = hvt_pkg::ACC_W;
  localparam int HI_SH = hvt_pkg::FRAC_W + 1;
  localparam int QW    = hvt_pkg::QUO_W;
  localparam int CW    = hvt_pkg::COORD_W;

  hvt_pkg::hvt_div_state_t state, state_next;

  logic             neg;
  logic             big;
  logic [MAG_W-1:0] n;
  logic [MAG_W-1:0] d;
  logic [MAG_W-1:0] r;
  logic [QW-1:0]    lo;
  logic [QW-1:0]    q;
  logic [5:0]       cnt;

  logic [MAG_W-1:0] n_hi;
  logic [MAG_W:0]   trial;
  logic             fits;
  logic             q_big_neg;
  logic             q_big_pos;

  // The top 33 dividend bits alone; if they already reach d the quotient is at least 2^33.
  assign n_hi  = {{HI_SH{1'b0}}, n[MAG_W-1:HI_SH]};
  assign trial = {r, lo[QW-1]};
  assign fits  = trial >= {1'b0, d};

  assign q_big_neg = q[QW-1] || (q[CW-1] && (|q[CW-2:0]));
  assign q_big_pos = q[QW-1] || q[CW-1];

  always_comb begin
    state_next = state;
    unique case (state)
      hvt_pkg::DV_IDLE: if (start) state_next = hvt_pkg::DV_PREP;
      hvt_pkg::DV_PREP: state_next = (n_hi >= d) ? hvt_pkg::DV_DONE : hvt_pkg::DV_ITER;
      hvt_pkg::DV_ITER: if (cnt == '0) state_next = hvt_pkg::DV_DONE;
      hvt_pkg::DV_DONE: state_next = hvt_pkg::DV_IDLE;
      default:          state_next = hvt_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == hvt_pkg::DV_DONE);
    if (neg) begin
      ovf = big || q_big_neg;
      quo = ovf ? hvt_pkg::COORD_MIN : (~q[CW-1:0] + 32'd1);
    end else begin
      ovf = big || q_big_pos;
      quo = ovf ? hvt_pkg::COORD_MAX : q[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hvt_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hvt_pkg::DV_IDLE: begin
        if (start) begin
          neg <= num[MAG_W-1] ^ den[MAG_W-1];
          n   <= num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
          d   <= den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
        end
      end
      hvt_pkg::DV_PREP: begin
        big <= (n_hi >= d);
        r   <= n_hi;
        lo  <= {n[hvt_pkg::FRAC_W:0], {hvt_pkg::FRAC_W{1'b0}}};
        q   <= '0;
        cnt <= 6'(QW - 1);
      end
      hvt_pkg::DV_ITER: begin
        r   <= fits ? MAG_W'(trial - {1'b0, d}) : trial[MAG_W-1:0];
        q   <= {q[QW-2:0], fits};
        lo  <= {lo[QW-2:0], 1'b0};
        cnt <= cnt - 6'd1;
      end
      hvt_pkg::DV_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### src/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous 4x4 vertex transform unit with perspective divide.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | hvt_pkg::hvt_req_t
//   rsp     | out       | rsp_valid / rsp_ready | hvt_pkg::hvt_rsp_t
//
// A load transaction gives no response.
// A transform runs twelve multiply-accumulates on the single 32x32 multiplier, then
// three runs of the one-bit-per-cycle restoring divider.
// A zero w skips the divider.
// Reset is synchronous and restores the identity matrix.
// The response register frees the datapath; a stalled response holds only the final step.
module homogeneous_vertex_transform_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hvt_pkg::hvt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hvt_pkg::hvt_rsp_t rsp
);

  localparam int CW = hvt_pkg::COORD_W;
  localparam int AW = hvt_pkg::ACC_W;

  hvt_pkg::hvt_state_t state, state_next;

  logic signed [CW-1:0]               mat [16];
  logic signed [CW-1:0]               vtx [3];
  logic signed [AW-1:0]               acc [4];
  logic signed [CW-1:0]               quo [3];
  logic signed [hvt_pkg::PROD_W-1:0]  prod;
  logic [1:0]                         col;
  logic [1:0]                         row;
  logic                               zero_flag;
  logic                               ovf_acc;

  logic                               req_fire;
  logic                               rsp_load;
  logic                               div_start;
  logic                               div_done;
  logic signed [CW-1:0]               div_quo;
  logic                               div_ovf;
  logic signed [AW-1:0]               term;
  logic signed [CW-1:0]               bias_coef;
  hvt_pkg::hvt_rsp_t                  rsp_next;

  assign req_fire  = req_valid && req_ready;
  assign term      = {{(AW - hvt_pkg::TERM_W){prod[hvt_pkg::PROD_W-1]}},
                      prod[hvt_pkg::PROD_W-1:hvt_pkg::FRAC_W]};
  assign bias_coef = mat[{2'd3, col}];

  hvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc[col]),
    .den   (acc[3]),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      hvt_pkg::ST_IDLE: begin
        if (req_fire && req.op == hvt_pkg::OP_XFORM) state_next = hvt_pkg::ST_INIT;
      end
      hvt_pkg::ST_INIT: state_next = hvt_pkg::ST_MUL;
      hvt_pkg::ST_MUL:  state_next = hvt_pkg::ST_ACC;
      hvt_pkg::ST_ACC: begin
        if (row == 2'd2) begin
          state_next = (col == 2'd3) ? hvt_pkg::ST_CHECK : hvt_pkg::ST_INIT;
        end else begin
          state_next = hvt_pkg::ST_MUL;
        end
      end
      hvt_pkg::ST_CHECK: begin
        state_next = (acc[3] == '0) ? hvt_pkg::ST_OUT : hvt_pkg::ST_DIV_GO;
      end
      hvt_pkg::ST_DIV_GO: state_next = hvt_pkg::ST_DIV_WAIT;
      hvt_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = (col == 2'd2) ? hvt_pkg::ST_OUT : hvt_pkg::ST_DIV_GO;
      end
      hvt_pkg::ST_OUT: if (rsp_load) state_next = hvt_pkg::ST_IDLE;
      default: state_next = hvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == hvt_pkg::ST_IDLE);
    div_start = (state == hvt_pkg::ST_DIV_GO);
    rsp_load  = (state == hvt_pkg::ST_OUT) && (!rsp_valid || rsp_ready);
    if (zero_flag) begin
      rsp_next = '{out_x: '0, out_y: '0, out_z: '0, zero_w: 1'b1, overflow: 1'b0};
    end else begin
      rsp_next = '{out_x: quo[0], out_y: quo[1], out_z: quo[2], zero_w: 1'b0,
                   overflow: ovf_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hvt_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= hvt_pkg::identity_coef(4'(i));
      end
    end else if (req_fire && req.op == hvt_pkg::OP_LOAD) begin
      mat[req.coef_index] <= req.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hvt_pkg::ST_IDLE: begin
        if (req_fire) begin
          vtx[0] <= req.in_x;
          vtx[1] <= req.in_y;
          vtx[2] <= req.in_z;
          col    <= 2'd0;
          row    <= 2'd0;
        end
      end
      hvt_pkg::ST_INIT: begin
        // The constant 1 in the vertex adds the bottom row coefficient exactly.
        acc[col] <= {{(AW - CW){bias_coef[CW-1]}}, bias_coef};
        row      <= 2'd0;
      end
      hvt_pkg::ST_MUL: begin
        prod <= vtx[row] * mat[{row, col}];
      end
      hvt_pkg::ST_ACC: begin
        acc[col] <= acc[col] + term;
        if (row == 2'd2) begin
          row <= 2'd0;
          col <= col + 2'd1;
        end else begin
          row <= row + 2'd1;
        end
      end
      hvt_pkg::ST_CHECK: begin
        col       <= 2'd0;
        ovf_acc   <= 1'b0;
        zero_flag <= (acc[3] == '0);
      end
      hvt_pkg::ST_DIV_GO: begin
      end
      hvt_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          quo[col] <= div_quo;
          ovf_acc  <= ovf_acc | div_ovf;
          col      <= col + 2'd1;
        end
      end
      hvt_pkg::ST_OUT: begin
        if (rsp_load) rsp <= rsp_next;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/hvt_checker.sv
// Port-level checker for the vertex transform unit and its bind to the top level.
module hvt_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input hvt_pkg::hvt_req_t req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input hvt_pkg::hvt_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed or dropped while stalled");

  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.zero_w |-> rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0
                                && !rsp.overflow)
    else $error("zero w response with nonzero coordinates or overflow");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> !rsp.zero_w &&
      (rsp.out_x == hvt_pkg::COORD_MAX || rsp.out_x == hvt_pkg::COORD_MIN ||
       rsp.out_y == hvt_pkg::COORD_MAX || rsp.out_y == hvt_pkg::COORD_MIN ||
       rsp.out_z == hvt_pkg::COORD_MAX || rsp.out_z == hvt_pkg::COORD_MIN))
    else $error("overflow flagged without a saturated coordinate");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.op == hvt_pkg::OP_XFORM |=> !req_ready)
    else $error("transform transaction did not make the unit busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
